>>> rtl/spq_pkg.sv
// Shared types and constants for the sorted min-priority queue.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    localparam logic signed [VALUE_W-1:0] EMPTY_HEAD = '1;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        value_t value;
    } op_t;

endpackage

`default_nettype wire

>>> rtl/spq_cell.sv
// One slot of the sorted chain: holds a value, keeps, takes the new word or
// shifts from a neighbour. Depends on spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic   aclk,
    input  wire op_t    op,
    input  wire logic   occ,
    input  wire value_t left_val,
    input  wire logic   left_keep,
    input  wire value_t right_val,
    output value_t      val,
    output value_t      val_next,
    output logic        keep
);

    value_t val_reg;

    assign keep = occ && (val_reg < op.value);
    assign val  = val_reg;

    always_comb begin
        val_next = val_reg;
        if (op.push) begin
            if (!keep) begin
                val_next = left_keep ? op.value : left_val;
            end
        end else if (op.pop) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.push || op.pop) begin
            val_reg <= val_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sorted_min_priority_queue_core.sv
// Sorted min-priority queue: usage notes.
// Input channel s_*: s_kind selects push (insert s_value) or pop (drop the head).
// Output channel m_*: one word per input word with m_status (done, pop on
// empty, push on full dropped), m_head_value (-1 when empty), m_count and
// m_empty_res, all describing the queue after the operation.
// Values sit in a row of CAPACITY cells in ascending order; every cell
// compares its value with the pushed one and keeps, takes it or shifts in
// the same cycle, so an operation completes in the cycle it is accepted.
// The result is registered and appears on m_* in the cycle after acceptance.
// Throughput: one word per cycle while the receiver takes each result, set by
// the cell update and the one output register.
// A stalled receiver holds the output register; s_ready drops until it is
// taken, so no word is lost.
// Reset (aresetn low, synchronous) empties the queue and clears m_valid;
// cell contents are left as they are and are not read until written.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_min_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_kind,
    input  wire logic signed [VALUE_W-1:0] s_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic signed [VALUE_W-1:0] m_head_value,
    output logic [COUNT_W-1:0]       m_count,
    output logic                     m_empty_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      m_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    value_t                    head_reg;
    logic [CNT_W-1:0]          out_count_reg;
    logic                      empty_reg;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [STATUS_W-1:0]       status_next;
    op_t                       op;

    value_t                    cell_val  [CAPACITY];
    value_t                    cell_nxt  [CAPACITY];
    logic                      cell_keep [CAPACITY];

    logic [CNT_W+COUNT_W-1:0]  count_ext;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        op.push     = accept && (s_kind == KIND_PUSH) && !full;
        op.pop      = accept && (s_kind == KIND_POP) && !empty;
        op.value    = s_value;
        status_next = ST_DONE;
        if (s_kind == KIND_PUSH && full) begin
            status_next = ST_PUSH_FULL;
        end else if (s_kind == KIND_POP && empty) begin
            status_next = ST_POP_EMPTY;
        end
        count_next = count_reg;
        if (op.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (op.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        value_t lv;
        logic   lk;
        value_t rv;
        logic   occ;

        if (g == 0) begin : g_first
            assign lv = s_value;
            assign lk = 1'b1;
        end else begin : g_mid
            assign lv = cell_val[g-1];
            assign lk = cell_keep[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign rv = cell_val[g];
        end else begin : g_body
            assign rv = cell_val[g+1];
        end

        assign occ = (CNT_W'(g) < count_reg);

        spq_cell u_cell (
            .aclk      (aclk),
            .op        (op),
            .occ       (occ),
            .left_val  (lv),
            .left_keep (lk),
            .right_val (rv),
            .val       (cell_val[g]),
            .val_next  (cell_nxt[g]),
            .keep      (cell_keep[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            head_reg      <= (count_next == '0) ? EMPTY_HEAD : cell_nxt[0];
            out_count_reg <= count_next;
            empty_reg     <= (count_next == '0);
        end
    end

    assign count_ext    = {{COUNT_W{1'b0}}, out_count_reg};
    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_head_value = head_reg;
    assign m_count      = count_ext[COUNT_W-1:0];
    assign m_empty_res  = empty_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word gave no result");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        op.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the queue");

    a_pop_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_POP_EMPTY |-> m_empty_res && out_count_reg == '0)
        else $error("pop on empty reported a non-empty queue");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PUSH_FULL |-> out_count_reg == CNT_W'(CAPACITY))
        else $error("push dropped while not full");

endmodule

`default_nettype wire
